@@ hdl/splm_pkg.sv @@
// ----------------------------------------------------------------------------
// splm_pkg: shared types and constants of the stereo peak limiter
// Register indices, sequencer states, fixed-point constants and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package splm_pkg;

  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 25;
  localparam int GAIN_BITS     = 24;
  localparam int COEF_BITS     = 25;
  localparam int ENV_BITS      = 32;
  localparam int DIV_N_BITS    = 50;
  localparam int DIV_D_BITS    = 32;

  localparam logic [ENV_BITS-1:0]  ENV_ONE     = 32'd16777216;
  localparam logic [ENV_BITS-1:0]  ENV_ACTIVE  = 32'd16787282;
  localparam logic [ENV_BITS-1:0]  ENV_FIRED   = 32'd17772104;
  localparam logic [ENV_BITS-1:0]  ENV_MAX     = 32'hFFFF_FFFF;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE    = 24'd8388608;
  localparam logic [GAIN_BITS-1:0] CEIL_MIN    = 24'd8;
  localparam logic [GAIN_BITS-1:0] DC_COEF_MAX = 24'd16775538;
  localparam logic [GAIN_BITS-1:0] TRIM_RST    = 24'd1048576;
  localparam logic [COEF_BITS-1:0] COEF_ONE    = 25'd16777216;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LIM_EN    = 3'd0,
    CFG_DC_EN     = 3'd1,
    CFG_CEILING   = 3'd2,
    CFG_TRIM      = 3'd3,
    CFG_ATTACK    = 3'd4,
    CFG_RELEASE   = 3'd5,
    CFG_RMS       = 3'd6,
    CFG_DC_COEF   = 3'd7
  } splm_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC_L,
    ST_DC_R,
    ST_TRIM_L,
    ST_TRIM_R,
    ST_PEAK,
    ST_TGT_DIV,
    ST_ENV_MUL,
    ST_GAIN_DIV,
    ST_GAIN_L,
    ST_GAIN_R,
    ST_OCLAMP,
    ST_SQ_MUL,
    ST_MS_MUL,
    ST_DONE
  } splm_state_t;

endpackage

`default_nettype wire

@@ hdl/splm_mul.sv @@
// ----------------------------------------------------------------------------
// splm_mul: bit-serial shift-add multiplier
// Signed a times unsigned b, one bit of b per cycle, done pulses when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module splm_mul
  import splm_pkg::*;
#(
  parameter int AW = 34,
  parameter int BW = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic [BW-1:0]        b,
  output logic                      done,
  output logic signed [AW+BW-1:0]   p
);

  localparam int CW = $clog2(BW);
  localparam logic [CW-1:0] CNT_LAST = CW'(BW - 1);

  logic signed [AW-1:0] a_r;
  logic signed [AW:0]   hi_r;
  logic [BW-1:0]        lo_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic signed [AW:0]   addend;
  logic signed [AW:0]   sum;

  always_comb begin
    addend = lo_r[0] ? {a_r[AW-1], a_r} : '0;
    sum    = hi_r + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= {sum[AW], sum[AW:1]};
      lo_r <= {sum[0], lo_r[BW-1:1]};
    end
  end

  assign done = done_r;
  assign p    = $signed({hi_r[AW-1:0], lo_r});

endmodule

`default_nettype wire

@@ hdl/splm_div.sv @@
// ----------------------------------------------------------------------------
// splm_div: bit-serial restoring divider
// Unsigned quotient of num by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module splm_div
  import splm_pkg::*;
#(
  parameter int NW = DIV_N_BITS,
  parameter int DW = DIV_D_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW);
  localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] num_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem_r, num_r[NW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      num_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_r <= {num_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

`default_nettype wire

@@ hdl/stereo_peak_limiter_core.sv @@
// ----------------------------------------------------------------------------
// stereo_peak_limiter_core: feed-forward stereo peak limiter with DC blocker
// Usage: one frame request enters on in_valid/in_ready, one result request
// leaves on out_valid/out_ready for every frame. Settings are written on
// cfg_we/cfg_index/cfg_wdata while no frame is in flight; the user must keep to this, as the core does not enforce it.
// Each frame runs through a sequencer that shares one bit-serial multiplier
// and one bit-serial divider. Which steps a frame runs depends on whether the
// DC blocker and the limiter are on and on whether gain reduction is active;
// a new frame can be taken from the cycle after the previous result is loaded.
// The finished result sits in an output register, so a new frame is taken
// while the receiver stalls; a frame then waits at its end until the output
// register is free. Reset clears the envelope to unity, the DC blocker and
// mean-square state to zero, the block meters and all settings to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_peak_limiter_core
  import splm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]   cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input  wire logic                       in_is_stereo,
  input  wire logic                       in_last_in_block,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_BITS-1:0]   out_left,
  output logic signed [SAMPLE_BITS-1:0]   out_right,
  output logic [GAIN_BITS-1:0]            out_applied_gain,
  output logic                            out_clip_flag,
  output logic                            out_fired_flag,
  output logic                            out_block_end,
  output logic [SAMPLE_BITS+1:0]          out_block_in_peak,
  output logic [SAMPLE_BITS-2:0]          out_block_out_peak,
  output logic [GAIN_BITS-1:0]            out_block_min_gain,
  output logic [COUNT_BITS-1:0]           out_block_fired_count,
  output logic [COUNT_BITS-1:0]           out_block_clip_count,
  output logic [GAIN_BITS-1:0]            out_mean_square
);

  localparam int S  = SAMPLE_BITS;
  localparam int W  = S + 4;
  localparam int MA = (S + 4 > 34) ? S + 4 : 34;
  localparam int MB = (S - 1 > COEF_BITS) ? S - 1 : COEF_BITS;
  localparam int PW = MA + MB;

  localparam longint DC_LIM   = longint'(1) <<< (S + 3);
  localparam longint PIN_MAX  = (longint'(1) <<< (S + 2)) - 1;
  localparam longint FULL     = longint'(1) <<< (S - 1);
  localparam longint CLIP_THR = (FULL * 999 + 999) / 1000;

  localparam logic signed [PW-1:0] P_DC_HI   = PW'(DC_LIM - 1);
  localparam logic signed [PW-1:0] P_DC_LO   = PW'(-DC_LIM);
  localparam logic signed [PW-1:0] P_PIN_HI  = PW'(PIN_MAX);
  localparam logic signed [PW-1:0] P_PIN_LO  = PW'(-PIN_MAX);
  localparam logic signed [PW-1:0] P_S_HI    = PW'(FULL - 1);
  localparam logic signed [PW-1:0] P_S_LO    = PW'(-FULL);
  localparam logic signed [PW-1:0] P_ENV_ONE = PW'(ENV_ONE);
  localparam logic signed [PW-1:0] P_ENV_ACT = PW'(ENV_ACTIVE);
  localparam logic signed [PW-1:0] P_ENV_FIR = PW'(ENV_FIRED);
  localparam logic signed [PW-1:0] P_ENV_MAX = PW'(ENV_MAX);
  localparam logic signed [PW-1:0] P_ZERO    = '0;
  localparam logic signed [PW-1:0] P_Q23     = PW'(GAIN_ONE);
  localparam logic [S+1:0]         CLIP_V    = (S + 2)'(CLIP_THR);
  localparam logic [DIV_N_BITS-1:0] GAIN_NUM = DIV_N_BITS'(1) << 47;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

  function automatic logic signed [PW-1:0] sat_p(input logic signed [PW-1:0] v,
                                                  input logic signed [PW-1:0] lo,
                                                  input logic signed [PW-1:0] hi);
    logic signed [PW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // settings
  logic                  lim_en_r, dc_en_r;
  logic [GAIN_BITS-1:0]  ceil_r, trim_r, dc_coef_r;
  logic [COEF_BITS-1:0]  attack_r, release_r, rms_r;

  // sequencer
  splm_state_t state_r, state_nxt;
  logic        issued_r;
  logic        mul_start, div_start, out_load, out_free;

  // frame payload
  logic signed [S-1:0]   xl_r, xr_r;
  logic                  last_r;
  logic signed [W-1:0]   l_r, r_r;
  logic [S+1:0]          max_in_r;
  logic                  clip_r, fired_r;
  logic [ENV_BITS-1:0]   target_r;
  logic [GAIN_BITS-1:0]  gain_r;
  logic [S-2:0]          maxo_r;
  logic [S-2:0]          sq_r;

  // persistent state
  logic [ENV_BITS-1:0]   env_r;
  logic signed [S-1:0]   pin_l_r, pin_r_r;
  logic signed [W-1:0]   pout_l_r, pout_r_r;
  logic [GAIN_BITS-1:0]  acc_r;
  logic [S+1:0]          pk_in_r;
  logic [S-2:0]          pk_out_r;
  logic [GAIN_BITS-1:0]  min_gain_r;
  logic [COUNT_BITS-1:0] fired_cnt_r, clip_cnt_r;

  // output register
  logic                  out_valid_r;

  // shared units
  logic signed [MA-1:0]  mul_a;
  logic [MB-1:0]         mul_b;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_p;
  logic [DIV_N_BITS-1:0] div_num;
  logic [DIV_D_BITS-1:0] div_den;
  logic                  div_done;
  logic [DIV_N_BITS-1:0] div_q;

  // arithmetic around the units
  logic [GAIN_BITS-1:0]  dca, ceil_c;
  logic [COEF_BITS-1:0]  att_c, rel_c, rms_c, c_sel;
  logic signed [PW-1:0]  p_sh24, p_sh20, p_sh23, p_shs;
  logic signed [PW-1:0]  dc_y_l, dc_y_r, trim_v, env_upd, ms_upd;
  logic signed [ENV_BITS:0] env_diff;
  logic signed [MA-1:0]  ms_diff;
  logic [S+1:0]          abs_l, abs_r;
  logic signed [PW-1:0]  lc, rc, alc, arc, mo;
  logic [ENV_BITS-1:0]   tgt_c;
  logic [S+1:0]          pk_in_n;
  logic [S-2:0]          pk_out_n;
  logic [GAIN_BITS-1:0]  min_gain_n;
  logic [COUNT_BITS-1:0] fired_cnt_n, clip_cnt_n;

  splm_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  splm_div #(.NW(DIV_N_BITS), .DW(DIV_D_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  // coefficient clamps
  always_comb begin
    dca    = (dc_coef_r > DC_COEF_MAX) ? DC_COEF_MAX : dc_coef_r;
    ceil_c = (ceil_r < CEIL_MIN) ? CEIL_MIN : ((ceil_r > GAIN_ONE) ? GAIN_ONE : ceil_r);
    att_c  = (attack_r > COEF_ONE) ? COEF_ONE : attack_r;
    rel_c  = (release_r > COEF_ONE) ? COEF_ONE : release_r;
    rms_c  = (rms_r > COEF_ONE) ? COEF_ONE : rms_r;
    c_sel  = (target_r > env_r) ? att_c : rel_c;
  end

  // datapath arithmetic
  always_comb begin
    p_sh24   = mul_p >>> 24;
    p_sh20   = mul_p >>> 20;
    p_sh23   = mul_p >>> 23;
    p_shs    = mul_p >>> (S - 1);
    dc_y_l   = sat_p(PW'(xl_r) - PW'(pin_l_r) + p_sh24, P_DC_LO, P_DC_HI);
    dc_y_r   = sat_p(PW'(xr_r) - PW'(pin_r_r) + p_sh24, P_DC_LO, P_DC_HI);
    trim_v   = sat_p(p_sh20, P_PIN_LO, P_PIN_HI);
    env_diff = $signed({1'b0, target_r}) - $signed({1'b0, env_r});
    env_upd  = sat_p($signed(PW'(env_r)) + p_sh24, P_ENV_ONE, P_ENV_MAX);
    ms_diff  = $signed(MA'(sq_r)) - $signed(MA'(acc_r));
    ms_upd   = sat_p($signed(PW'(acc_r)) + p_sh24, P_ZERO, P_Q23);
    abs_l    = (S + 2)'((l_r < 0) ? -l_r : l_r);
    abs_r    = (S + 2)'((r_r < 0) ? -r_r : r_r);
    lc       = sat_p(PW'(l_r), P_S_LO, P_S_HI);
    rc       = sat_p(PW'(r_r), P_S_LO, P_S_HI);
    alc      = (lc < 0) ? -lc : lc;
    arc      = (rc < 0) ? -rc : rc;
    mo       = (alc > arc) ? alc : arc;
    if (mo > P_S_HI) mo = P_S_HI;
    if (div_q < DIV_N_BITS'(ENV_ONE)) tgt_c = ENV_ONE;
    else if (div_q > DIV_N_BITS'(ENV_MAX)) tgt_c = ENV_MAX;
    else tgt_c = div_q[ENV_BITS-1:0];
  end

  // block meters including this frame
  always_comb begin
    pk_in_n     = (max_in_r > pk_in_r) ? max_in_r : pk_in_r;
    pk_out_n    = (maxo_r > pk_out_r) ? maxo_r : pk_out_r;
    min_gain_n  = (gain_r < min_gain_r) ? gain_r : min_gain_r;
    fired_cnt_n = (fired_r && fired_cnt_r != CNT_MAX) ? fired_cnt_r + COUNT_BITS'(1)
                                                      : fired_cnt_r;
    clip_cnt_n  = (clip_r && clip_cnt_r != CNT_MAX) ? clip_cnt_r + COUNT_BITS'(1)
                                                    : clip_cnt_r;
  end

  // operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    case (state_r)
      ST_DC_L: begin
        mul_a = MA'(pout_l_r);
        mul_b = MB'(dca);
      end
      ST_DC_R: begin
        mul_a = MA'(pout_r_r);
        mul_b = MB'(dca);
      end
      ST_TRIM_L: begin
        mul_a = MA'(l_r);
        mul_b = MB'(trim_r);
      end
      ST_TRIM_R: begin
        mul_a = MA'(r_r);
        mul_b = MB'(trim_r);
      end
      ST_TGT_DIV: begin
        div_num = {max_in_r, {(48 - S){1'b0}}};
        div_den = DIV_D_BITS'(ceil_c);
      end
      ST_ENV_MUL: begin
        mul_a = MA'(env_diff);
        mul_b = MB'(c_sel);
      end
      ST_GAIN_DIV: begin
        div_num = GAIN_NUM;
        div_den = env_r;
      end
      ST_GAIN_L: begin
        mul_a = MA'(l_r);
        mul_b = MB'(gain_r);
      end
      ST_GAIN_R: begin
        mul_a = MA'(r_r);
        mul_b = MB'(gain_r);
      end
      ST_SQ_MUL: begin
        mul_a = $signed(MA'(maxo_r));
        mul_b = MB'(maxo_r);
      end
      ST_MS_MUL: begin
        mul_a = ms_diff;
        mul_b = MB'(rms_c);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = dc_en_r ? ST_DC_L : ST_TRIM_L;
      ST_DC_L:     if (mul_done) state_nxt = ST_DC_R;
      ST_DC_R:     if (mul_done) state_nxt = ST_TRIM_L;
      ST_TRIM_L:   if (mul_done) state_nxt = ST_TRIM_R;
      ST_TRIM_R:   if (mul_done) state_nxt = ST_PEAK;
      ST_PEAK:     state_nxt = lim_en_r ? ST_TGT_DIV : ST_OCLAMP;
      ST_TGT_DIV:  if (div_done) state_nxt = ST_ENV_MUL;
      ST_ENV_MUL:  if (mul_done) state_nxt = (env_upd > P_ENV_ACT) ? ST_GAIN_DIV : ST_OCLAMP;
      ST_GAIN_DIV: if (div_done) state_nxt = ST_GAIN_L;
      ST_GAIN_L:   if (mul_done) state_nxt = ST_GAIN_R;
      ST_GAIN_R:   if (mul_done) state_nxt = ST_OCLAMP;
      ST_OCLAMP:   state_nxt = ST_SQ_MUL;
      ST_SQ_MUL:   if (mul_done) state_nxt = ST_MS_MUL;
      ST_MS_MUL:   if (mul_done) state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    out_free  = !out_valid_r || out_ready;
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:     in_ready = 1'b1;
      ST_DC_L, ST_DC_R, ST_TRIM_L, ST_TRIM_R, ST_ENV_MUL,
      ST_GAIN_L, ST_GAIN_R, ST_SQ_MUL, ST_MS_MUL:
                   mul_start = !issued_r;
      ST_TGT_DIV, ST_GAIN_DIV:
                   div_start = !issued_r;
      ST_DONE:     out_load = out_free;
      default:     in_ready = 1'b0;
    endcase
  end

  // control, settings and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      lim_en_r    <= 1'b0;
      dc_en_r     <= 1'b0;
      ceil_r      <= GAIN_ONE;
      trim_r      <= TRIM_RST;
      attack_r    <= COEF_ONE;
      release_r   <= COEF_ONE;
      rms_r       <= COEF_ONE;
      dc_coef_r   <= '0;
      env_r       <= ENV_ONE;
      pin_l_r     <= '0;
      pin_r_r     <= '0;
      pout_l_r    <= '0;
      pout_r_r    <= '0;
      acc_r       <= '0;
      pk_in_r     <= '0;
      pk_out_r    <= '0;
      min_gain_r  <= GAIN_ONE;
      fired_cnt_r <= '0;
      clip_cnt_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= (state_nxt != state_r) ? 1'b0 : (issued_r | mul_start | div_start);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (splm_cfg_t'(cfg_index))
          CFG_LIM_EN:  lim_en_r  <= cfg_wdata[0];
          CFG_DC_EN:   dc_en_r   <= cfg_wdata[0];
          CFG_CEILING: ceil_r    <= cfg_wdata[GAIN_BITS-1:0];
          CFG_TRIM:    trim_r    <= cfg_wdata[GAIN_BITS-1:0];
          CFG_ATTACK:  attack_r  <= cfg_wdata;
          CFG_RELEASE: release_r <= cfg_wdata;
          CFG_RMS:     rms_r     <= cfg_wdata;
          CFG_DC_COEF: dc_coef_r <= cfg_wdata[GAIN_BITS-1:0];
          default:     lim_en_r  <= lim_en_r;
        endcase
      end

      if (state_r == ST_DC_L && mul_done) begin
        pin_l_r  <= xl_r;
        pout_l_r <= W'(dc_y_l);
      end
      if (state_r == ST_DC_R && mul_done) begin
        pin_r_r  <= xr_r;
        pout_r_r <= W'(dc_y_r);
      end
      if (state_r == ST_ENV_MUL && mul_done) env_r <= env_upd[ENV_BITS-1:0];
      if (state_r == ST_MS_MUL && mul_done) acc_r <= ms_upd[GAIN_BITS-1:0];

      if (out_load) begin
        if (last_r) begin
          pk_in_r     <= '0;
          pk_out_r    <= '0;
          min_gain_r  <= GAIN_ONE;
          fired_cnt_r <= '0;
          clip_cnt_r  <= '0;
        end else begin
          pk_in_r     <= pk_in_n;
          pk_out_r    <= pk_out_n;
          min_gain_r  <= min_gain_n;
          fired_cnt_r <= fired_cnt_n;
          clip_cnt_r  <= clip_cnt_n;
        end
      end
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        xl_r    <= in_left_sample;
        xr_r    <= in_is_stereo ? in_right_sample : in_left_sample;
        l_r     <= W'(in_left_sample);
        r_r     <= W'(in_is_stereo ? in_right_sample : in_left_sample);
        last_r  <= in_last_in_block;
        gain_r  <= GAIN_ONE;
        fired_r <= 1'b0;
      end
      ST_DC_L:   if (mul_done) l_r <= W'(dc_y_l);
      ST_DC_R:   if (mul_done) r_r <= W'(dc_y_r);
      ST_TRIM_L: if (mul_done) l_r <= W'(trim_v);
      ST_TRIM_R: if (mul_done) r_r <= W'(trim_v);
      ST_PEAK: begin
        max_in_r <= (abs_l > abs_r) ? abs_l : abs_r;
        clip_r   <= ((abs_l > abs_r) ? abs_l : abs_r) >= CLIP_V;
      end
      ST_TGT_DIV: if (div_done) target_r <= tgt_c;
      ST_ENV_MUL: if (mul_done) fired_r <= env_upd > P_ENV_FIR;
      ST_GAIN_DIV: if (div_done) gain_r <= div_q[GAIN_BITS-1:0];
      ST_GAIN_L: if (mul_done) l_r <= W'(p_sh23);
      ST_GAIN_R: if (mul_done) r_r <= W'(p_sh23);
      ST_OCLAMP: begin
        l_r    <= W'(lc);
        r_r    <= W'(rc);
        maxo_r <= mo[S-2:0];
      end
      ST_SQ_MUL: if (mul_done) sq_r <= p_shs[S-2:0];
      default: begin
        last_r <= last_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left              <= l_r[S-1:0];
      out_right             <= r_r[S-1:0];
      out_applied_gain      <= gain_r;
      out_clip_flag         <= clip_r;
      out_fired_flag        <= fired_r;
      out_block_end         <= last_r;
      out_block_in_peak     <= last_r ? pk_in_n : '0;
      out_block_out_peak    <= last_r ? pk_out_n : '0;
      out_block_min_gain    <= last_r ? min_gain_n : '0;
      out_block_fired_count <= last_r ? fired_cnt_n : '0;
      out_block_clip_count  <= last_r ? clip_cnt_n : '0;
      out_mean_square       <= last_r ? acc_r : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/splm_chk.sv @@
// ----------------------------------------------------------------------------
// splm_chk: port-level checks of the stereo peak limiter
// Watches the request channels and result fields, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module splm_chk
  import splm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [SAMPLE_BITS-1:0] out_left,
  input wire logic [GAIN_BITS-1:0]          out_applied_gain,
  input wire logic                          out_fired_flag,
  input wire logic                          out_block_end,
  input wire logic [SAMPLE_BITS+1:0]        out_block_in_peak,
  input wire logic [SAMPLE_BITS-2:0]        out_block_out_peak,
  input wire logic [GAIN_BITS-1:0]          out_block_min_gain,
  input wire logic [COUNT_BITS-1:0]         out_block_fired_count,
  input wire logic [COUNT_BITS-1:0]         out_block_clip_count,
  input wire logic [GAIN_BITS-1:0]          out_mean_square
);

  // meters only show on a block end
  a_meters_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_block_end |-> out_block_in_peak == '0 && out_block_out_peak == '0 &&
      out_block_min_gain == '0 && out_block_fired_count == '0 &&
      out_block_clip_count == '0 && out_mean_square == '0)
    else $error("block meters set off block end");

  // fired implies real gain reduction
  a_fired_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired_flag |-> out_applied_gain < GAIN_ONE)
    else $error("fired without gain reduction");

  // one frame in work at a time
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_block_end))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stereo_peak_limiter_core splm_chk #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .COUNT_BITS  (COUNT_BITS)
) u_splm_chk (.*);

`default_nettype wire
